// ===== hdl/hfla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hfla_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned COUNT_W  = 7;

    // Default pool geometry: 64 handles starting at 0xCE41.
    localparam int unsigned DEF_HANDLE_COUNT = 64;
    localparam int unsigned DEF_HANDLE_BASE  = 32'hCE41;

    // The unused code 3 is served as a check by the default arms.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CHECK = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_EMPTY   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_APPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;  // clear one in-use bit per cycle
        logic load;   // capture the request
        logic look;   // read the spare queue and the in-use map
        logic apply;  // update state and load the response register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/hfla_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hfla_req_if
    import hfla_pkg::*;
();
    logic                valid;
    logic                ready;
    t_action             action;
    logic [HANDLE_W-1:0] handle_in;

    modport source (output valid, output action, output handle_in, input ready);
    modport sink   (input valid, input action, input handle_in, output ready);
endinterface

interface hfla_rsp_if
    import hfla_pkg::*;
();
    logic                valid;
    logic                ready;
    t_status             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output handle_out, output free_count,
                    input ready);
    modport sink   (input valid, input status, input handle_out, input free_count,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/hfla_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfla_datapath
    import hfla_pkg::*;
#(
    parameter int unsigned HANDLE_COUNT = DEF_HANDLE_COUNT,
    parameter int unsigned HANDLE_BASE  = DEF_HANDLE_BASE
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire t_action             i_action,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    output t_status                  o_status,
    output logic [HANDLE_W-1:0]      o_handle_out,
    output logic [COUNT_W-1:0]       o_free_count
);

    localparam int unsigned IW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
    localparam int unsigned TW = $clog2(HANDLE_COUNT + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(HANDLE_COUNT - 1);
    localparam logic [TW-1:0] FULL_CNT  = TW'(HANDLE_COUNT);

    // Memories: spare queue of handle indices and the in-use map.
    logic [IW-1:0] r_queue [0:HANDLE_COUNT-1];
    logic          r_map   [0:HANDLE_COUNT-1];

    // Control state.
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [TW-1:0] r_total, n_total;
    logic          r_wrapped, n_wrapped;
    logic [IW-1:0] r_clr_ptr, n_clr_ptr;

    // Request and lookup registers.
    t_action             r_action;
    logic [HANDLE_W-1:0] r_handle;
    logic [IW-1:0]       r_idx;
    logic                r_in_range;
    logic [IW-1:0]       r_qdata;
    logic                r_qwritten;
    logic                r_map_bit;

    // Response registers.
    t_status             r_status;
    logic [HANDLE_W-1:0] r_hout;
    logic [COUNT_W-1:0]  r_free_count;

    logic [HANDLE_W:0]   diff;
    logic                in_range;
    logic [IW-1:0]       pop_idx;
    t_status             n_status;
    logic [HANDLE_W-1:0] n_hout;
    logic                map_we;
    logic [IW-1:0]       map_wa;
    logic                map_wd;
    logic                q_we;

    // Range test of the captured handle against the pool window.
    assign diff     = {1'b0, r_handle} - (HANDLE_W + 1)'(HANDLE_BASE);
    assign in_range = !diff[HANDLE_W] && (diff[HANDLE_W-1:0] < HANDLE_W'(HANDLE_COUNT));

    // A queue slot that was never pushed reads back as its own index.
    assign pop_idx = r_qwritten ? r_qdata : r_head;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_total   = r_total;
        n_wrapped = r_wrapped;
        n_clr_ptr = r_clr_ptr;
        n_status  = STAT_OK;
        n_hout    = '0;
        map_we    = 1'b0;
        map_wa    = r_clr_ptr;
        map_wd    = 1'b0;
        q_we      = 1'b0;

        if (i_cmd.clear) begin
            map_we = 1'b1;
            if (r_clr_ptr != LAST_SLOT) begin
                n_clr_ptr = r_clr_ptr + 1'b1;
            end
        end else if (i_cmd.apply) begin
            case (r_action)
                ACT_ALLOC: begin
                    if (r_total == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_head  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                        n_total = r_total - 1'b1;
                        map_we  = 1'b1;
                        map_wa  = pop_idx;
                        map_wd  = 1'b1;
                        n_hout  = HANDLE_W'(HANDLE_BASE) + HANDLE_W'(pop_idx);
                    end
                end
                ACT_FREE: begin
                    if (!r_in_range || !r_map_bit || r_total >= FULL_CNT) begin
                        n_status = STAT_INVALID;
                    end else begin
                        map_we  = 1'b1;
                        map_wa  = r_idx;
                        q_we    = 1'b1;
                        n_total = r_total + 1'b1;
                        if (r_tail == LAST_SLOT) begin
                            n_tail    = '0;
                            n_wrapped = 1'b1;
                        end else begin
                            n_tail = r_tail + 1'b1;
                        end
                    end
                end
                default: begin
                    if (!r_in_range || !r_map_bit) begin
                        n_status = STAT_INVALID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_total   <= FULL_CNT;
            r_wrapped <= 1'b0;
            r_clr_ptr <= '0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_total   <= n_total;
            r_wrapped <= n_wrapped;
            r_clr_ptr <= n_clr_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_handle <= i_handle_in;
        end
        if (i_cmd.look) begin
            r_idx      <= diff[IW-1:0];
            r_in_range <= in_range;
            r_map_bit  <= r_map[diff[IW-1:0]];
            r_qdata    <= r_queue[r_head];
            r_qwritten <= r_wrapped || (r_head < r_tail);
        end
        if (i_cmd.apply) begin
            r_status     <= n_status;
            r_hout       <= n_hout;
            r_free_count <= COUNT_W'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wd;
        end
        if (q_we) begin
            r_queue[r_tail] <= r_idx;
        end
    end

    assign o_sts.clear_last = (r_clr_ptr == LAST_SLOT);
    assign o_status         = r_status;
    assign o_handle_out     = r_hout;
    assign o_free_count     = r_free_count;

    // The spare count never exceeds the pool size.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL_CNT)
        else $error("spare count above pool size");

    // Head and tail meet only when the queue is empty or full.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0 && r_total != FULL_CNT) |-> (r_head != r_tail))
        else $error("queue pointers disagree with spare count");

    // A successful allocate lowers the spare count by one.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && !i_cmd.clear && r_action == ACT_ALLOC && r_total != '0)
        |=> (r_total == $past(r_total) - 1'b1))
        else $error("allocate did not consume a spare handle");

endmodule

`default_nettype wire

// ===== hdl/hfla_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfla_ctrl
    import hfla_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // A response appears only as the result of an update step.
    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("response raised outside of an update");

    // An update never overwrites a response that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> (!r_out_valid || i_out_ready))
        else $error("response register overwritten");

endmodule

`default_nettype wire

// ===== hdl/handle_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Transaction when
// i_req     in   action[1:0], handle_in[15:0]              valid && ready
// o_rsp     out  status[1:0], handle_out[15:0],            valid && ready
//                free_count[6:0]
//
// A request passes through capture, a lookup step that reads the spare
// queue and the in-use map (both registered-read memories), and an update
// step that writes them and loads the response register.
// After reset the in-use map is cleared one entry per cycle, with i_req.ready
// held low. The spare queue needs no clearing: slots not yet pushed since
// reset read back their own index.
// A new request is taken while a response still waits; the update step of
// that request holds until the response register has been emptied.

module handle_free_list_allocator_core
    import hfla_pkg::*;
#(
    parameter int unsigned HANDLE_COUNT = DEF_HANDLE_COUNT,
    parameter int unsigned HANDLE_BASE  = DEF_HANDLE_BASE
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hfla_req_if.sink  i_req,
    hfla_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller sequences each transaction; the datapath owns all
    // storage and the response payload.
    hfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hfla_datapath #(
        .HANDLE_COUNT (HANDLE_COUNT),
        .HANDLE_BASE  (HANDLE_BASE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_req.action),
        .i_handle_in  (i_req.handle_in),
        .o_status     (o_rsp.status),
        .o_handle_out (o_rsp.handle_out),
        .o_free_count (o_rsp.free_count)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hfla_pkg::*;

    localparam int unsigned POOL_SIZE = DEF_HANDLE_COUNT;
    localparam int unsigned POOL_BASE = DEF_HANDLE_BASE;
    localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
    localparam int unsigned RUN_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 450;

    // Traffic mixes for the random bursts.
    typedef enum int {
        MIX_DRAIN,
        MIX_FILL,
        MIX_EVEN
    } t_mix;

    // Kinds of handle that a free or a check request carries.
    typedef enum int {
        PICK_IN_USE,
        PICK_IN_POOL,
        PICK_EDGE,
        PICK_ANY
    } t_pick;

    typedef struct {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    // Tracks the pool as the block should see it, and holds the replies that
    // accepted requests still owe.
    class pool_ledger;
        logic [IDX_W-1:0]   spare_ring [POOL_SIZE];
        logic [IDX_W-1:0]   ring_head;
        logic [IDX_W-1:0]   ring_tail;
        logic [COUNT_W-1:0] spare_cnt;
        bit                 in_use [POOL_SIZE];
        t_reply             owed_replies [$];
        int                 errors;

        function new();
            for (int i = 0; i < POOL_SIZE; i++) begin
                spare_ring[i] = IDX_W'(i);
                in_use[i] = 1'b0;
            end
            ring_head = '0;
            ring_tail = '0;
            spare_cnt = COUNT_W'(POOL_SIZE);
            errors = 0;
        endfunction

        // Offset of a handle inside the pool, or -1 when it lies outside.
        function int pool_offset(logic [HANDLE_W-1:0] h);
            int off;
            off = int'(h) - int'(POOL_BASE);
            if (off < 0 || off >= int'(POOL_SIZE)) return -1;
            return off;
        endfunction

        function logic [IDX_W-1:0] step_slot(logic [IDX_W-1:0] p);
            return (int'(p) == POOL_SIZE - 1) ? '0 : p + 1'b1;
        endfunction

        function void note_request(t_action act, logic [HANDLE_W-1:0] h);
            t_reply r;
            int off;
            logic [IDX_W-1:0] idx;
            r.status = STAT_OK;
            r.handle = '0;
            off = pool_offset(h);
            case (act)
                ACT_ALLOC: begin
                    if (spare_cnt == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        idx = spare_ring[ring_head];
                        ring_head = step_slot(ring_head);
                        spare_cnt = spare_cnt - 1'b1;
                        in_use[idx] = 1'b1;
                        r.handle = HANDLE_W'(POOL_BASE + idx);
                    end
                end
                ACT_FREE: begin
                    if (off < 0 || !in_use[off] || spare_cnt >= POOL_SIZE) begin
                        r.status = STAT_INVALID;
                    end else begin
                        in_use[off] = 1'b0;
                        spare_ring[ring_tail] = IDX_W'(off);
                        ring_tail = step_slot(ring_tail);
                        spare_cnt = spare_cnt + 1'b1;
                    end
                end
                // The check code and the unused code 3 only validate.
                default: begin
                    if (off < 0 || !in_use[off]) r.status = STAT_INVALID;
                end
            endcase
            r.count = spare_cnt;
            owed_replies.insert(owed_replies.size(), r);
        endfunction

        function void check_response(logic [1:0] st, logic [HANDLE_W-1:0] h,
                                     logic [COUNT_W-1:0] c);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $display("%0t: response with none outstanding: status %0d handle %h count %0d",
                         $time, st, h, c);
                errors++;
                return;
            end
            want = owed_replies[0];
            owed_replies.delete(0);
            if (st !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (h !== want.handle) begin
                $display("%0t: handle_out expected %h actual %h", $time, want.handle, h);
                errors++;
            end
            if (c !== want.count) begin
                $display("%0t: free_count expected %0d actual %0d", $time, want.count, c);
                errors++;
            end
        endfunction

        // A random handle that is currently allocated, or -1 if none is.
        function int pick_in_use();
            int held [$];
            for (int i = 0; i < POOL_SIZE; i++)
                if (in_use[i]) held.insert(held.size(), i);
            if (held.size() == 0) return -1;
            return int'(POOL_BASE) + held[$urandom_range(0, held.size() - 1)];
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned cycles = 0;
    bit calm = 1'b0;  // when set, neither side inserts idle cycles

    pool_ledger ledger = new();

    hfla_req_if req_bus ();
    hfla_rsp_if rsp_bus ();

    handle_free_list_allocator_core #(
        .HANDLE_COUNT(POOL_SIZE),
        .HANDLE_BASE (POOL_BASE)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int unsigned idle_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Offers one request after a random gap and returns once the block has
    // taken it. Valid stays high straight into the next request when there
    // is no gap.
    task automatic send_request(t_action act, logic [HANDLE_W-1:0] h);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk) req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_bus.valid     <= 1'b1;
        req_bus.action    <= act;
        req_bus.handle_in <= h;
        do @(posedge i_clk); while (!req_bus.ready);
        ledger.note_request(act, h);
    endtask

    function automatic logic [HANDLE_W-1:0] draw_handle();
        t_pick kind;
        int held;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        kind = roll < 50 ? PICK_IN_USE : roll < 70 ? PICK_IN_POOL :
               roll < 80 ? PICK_EDGE : PICK_ANY;
        case (kind)
            PICK_IN_USE: begin
                held = ledger.pick_in_use();
                if (held >= 0) return HANDLE_W'(held);
                return HANDLE_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
            end
            PICK_IN_POOL: return HANDLE_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
            PICK_EDGE: begin
                case ($urandom_range(0, 3))
                    0: return HANDLE_W'(POOL_BASE - 1);
                    1: return HANDLE_W'(POOL_BASE);
                    2: return HANDLE_W'(POOL_BASE + POOL_SIZE - 1);
                    default: return HANDLE_W'(POOL_BASE + POOL_SIZE);
                endcase
            end
            default: return HANDLE_W'($urandom());
        endcase
    endfunction

    // Picks the action of one random request according to the burst mix.
    function automatic t_action draw_action(t_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_DRAIN: return roll < 85 ? ACT_ALLOC : roll < 93 ? ACT_FREE :
                              roll < 97 ? ACT_CHECK : t_action'(2'd3);
            MIX_FILL:  return roll < 10 ? ACT_ALLOC : roll < 80 ? ACT_FREE :
                              roll < 93 ? ACT_CHECK : t_action'(2'd3);
            default:   return t_action'($urandom_range(0, 3));
        endcase
    endfunction

    // Response side: ready drops for a random number of cycles before each
    // transaction, and every response is checked as it is taken.
    initial begin
        int unsigned gap;
        rsp_bus.ready = 1'b0;
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                @(negedge i_clk) rsp_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            ledger.check_response(rsp_bus.status, rsp_bus.handle_out, rsp_bus.free_count);
        end
    end

    initial begin
        t_mix mix;
        int unsigned burst;
        int unsigned sent;
        req_bus.valid     = 1'b0;
        req_bus.action    = ACT_ALLOC;
        req_bus.handle_in = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests. The first two allocations hand out the two lowest
        // handles; the handle field is ignored on an allocate.
        send_request(ACT_ALLOC, 16'hFFFF);
        send_request(ACT_ALLOC, 16'h0000);
        send_request(ACT_CHECK, HANDLE_W'(POOL_BASE));
        // Code 3 must answer like a check.
        send_request(t_action'(2'd3), HANDLE_W'(POOL_BASE + 1));
        send_request(t_action'(2'd3), HANDLE_W'(POOL_BASE + 2));
        // Handles that are in the pool but were never handed out.
        send_request(ACT_CHECK, HANDLE_W'(POOL_BASE + POOL_SIZE - 1));
        send_request(ACT_FREE, HANDLE_W'(POOL_BASE + 5));
        // Handles just outside the pool and at the ends of the field.
        send_request(ACT_CHECK, HANDLE_W'(POOL_BASE - 1));
        send_request(ACT_CHECK, HANDLE_W'(POOL_BASE + POOL_SIZE));
        send_request(ACT_CHECK, 16'h0000);
        send_request(ACT_FREE, 16'hFFFF);
        send_request(ACT_FREE, HANDLE_W'(POOL_BASE - 1));
        // A good free, then a second free of the same handle.
        send_request(ACT_FREE, HANDLE_W'(POOL_BASE));
        send_request(ACT_FREE, HANDLE_W'(POOL_BASE));
        send_request(ACT_CHECK, HANDLE_W'(POOL_BASE));
        // The freed handle went to the back of the queue, so this takes base+2.
        send_request(ACT_ALLOC, 16'h5555);
        send_request(ACT_FREE, HANDLE_W'(POOL_BASE + 1));
        send_request(t_action'(2'd3), 16'hAAAA);

        // Random bursts. The first one drains the pool so that allocations
        // meet an empty pool early; later bursts mix draining and refilling.
        sent = 0;
        mix = MIX_DRAIN;
        burst = 90;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                t_action act;
                act = draw_action(mix);
                send_request(act, draw_handle());
                sent++;
            end
            mix = t_mix'($urandom_range(0, 2));
            burst = $urandom_range(10, 70);
            if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
        end
        calm = 1'b0;
        @(negedge i_clk) req_bus.valid <= 1'b0;

        while (ledger.owed_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (ledger.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== handle_free_list_allocator_core.f =====
hdl/hfla_pkg.sv
hdl/hfla_req_if.sv
hdl/hfla_datapath.sv
hdl/hfla_ctrl.sv
hdl/handle_free_list_allocator_core.sv
tb/sv/tb.sv
